// File: design/fcpm_pkg.sv
// ============================================================================
// Fan curve PWM map package
// Shared types, register codes, reset values and constants of the fan curve.
// ============================================================================
package fcpm_pkg;

    // Curve point storage
    localparam int POINT_SLOTS_DEF = 8;
    localparam int SLOT_W          = 16;
    localparam int SLOTS_PER_WORD  = 4;
    localparam int CFG_DATA_W      = 63;
    localparam int CFG_IDX_W       = 3;
    localparam int COUNT_W         = 4;

    // Curve and fallback constants
    localparam int TOP_TEMP     = 120;
    localparam int FULL_PERCENT = 100;

    // Percent to PWM scaling: x / 100 == (x * 5243) >> 19 for x below 43690
    localparam int PCT_RECIP = 5243;
    localparam int PCT_SHIFT = 19;

    // Percent output when the curve is not in use
    localparam logic signed [7:0] PCT_NONE = -8'sd1;

    // Divider geometry
    localparam int NUM_W   = 16;
    localparam int MAG_W   = 15;
    localparam int QUO_W   = 8;
    localparam int DIV_BPS = 2;

    // Queue between the front and the back end
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [7:0] FULL_PWM_RST = 8'd255;
    localparam logic [7:0] FB_PWM_RST   = 8'd35;
    localparam logic [7:0] FB_TEMP_RST  = 8'd45;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PTS_LO   = 3'd0,
        REG_PTS_HI   = 3'd1,
        REG_COUNT    = 3'd2,
        REG_FULL_PWM = 3'd3,
        REG_FB_PWM   = 3'd4,
        REG_FB_TEMP  = 3'd5
    } t_reg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pts_lo;
        logic [CFG_DATA_W-1:0] pts_hi;
        logic [COUNT_W-1:0]    point_count;
        logic [7:0]            full_pwm;
        logic [7:0]            fb_start_pwm;
        logic [7:0]            fb_start_temp;
    } t_cfg;

    // Information that travels beside the division
    typedef struct packed {
        logic       is_curve;
        logic       t_pos;
        logic [7:0] addend;
    } t_side;

    // One queued item: result = addend + num / den (truncating)
    typedef struct packed {
        t_side                   side;
        logic signed [NUM_W-1:0] num;
        logic [7:0]              den;
    } t_item;

    // A full-scale value of zero counts as 255.
    function automatic logic [7:0] eff_max(input logic [7:0] full);
        return (full == 8'd0) ? 8'hFF : full;
    endfunction

    // Temperature of curve point k.
    function automatic logic [7:0] slot_temp(input t_cfg cfg, input int k);
        logic [CFG_DATA_W-1:0] word;
        word = (k < SLOTS_PER_WORD) ? cfg.pts_lo : cfg.pts_hi;
        return word[SLOT_W*(k % SLOTS_PER_WORD) +: 8];
    endfunction

    // Percent of curve point k.
    function automatic logic [6:0] slot_pct(input t_cfg cfg, input int k);
        logic [CFG_DATA_W-1:0] word;
        word = (k < SLOTS_PER_WORD) ? cfg.pts_lo : cfg.pts_hi;
        return word[SLOT_W*(k % SLOTS_PER_WORD) + 8 +: 7];
    endfunction

endpackage

// File: design/fcpm_front.sv
// ============================================================================
// Fan curve front end
// Classifies each temperature against the curve or the fallback line and
// forms the numerator, denominator and addend of its interpolation.
// ============================================================================
module fcpm_front #(
    parameter int POINT_SLOTS = fcpm_pkg::POINT_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcpm_pkg::t_cfg      i_cfg,
    input  logic                i_accept,
    input  logic signed [8:0]   i_temperature,
    output logic                o_push,
    output fcpm_pkg::t_item     o_item
);

    localparam int IDX_W = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;

    typedef enum logic [4:0] {
        K_PCT_CONST = 5'b00001,
        K_PCT_SEG   = 5'b00010,
        K_FB_ZERO   = 5'b00100,
        K_FB_FULL   = 5'b01000,
        K_FB_LINE   = 5'b10000
    } t_kind;

    logic [7:0]                 pt_temp [POINT_SLOTS];
    logic [6:0]                 pt_pct  [POINT_SLOTS];
    logic [7:0]                 maxp;

    logic signed [9:0]          t_in;
    logic [3:0]                 n_sat;
    logic [IDX_W-1:0]           last;
    logic [POINT_SLOTS-1:0]     le;
    logic                       seg_found;
    logic [IDX_W-1:0]           seg_idx;
    t_kind                      n_kind;
    logic [IDX_W-1:0]           n_idx;

    logic                       r_vld;
    t_kind                      r_kind;
    logic [IDX_W-1:0]           r_idx;
    logic signed [9:0]          r_t;

    logic [IDX_W-1:0]           idx_hi;
    logic [7:0]                 t0;
    logic [7:0]                 t1;
    logic [6:0]                 p0;
    logic [6:0]                 p1;
    logic signed [9:0]          dt;
    logic signed [9:0]          mul_a;
    logic signed [8:0]          mul_b;
    logic signed [18:0]         prod;

    // Unpack the curve points from the two point registers.
    always_comb begin
        for (int k = 0; k < POINT_SLOTS; k++) begin
            pt_temp[k] = fcpm_pkg::slot_temp(i_cfg, k);
            pt_pct[k]  = fcpm_pkg::slot_pct(i_cfg, k);
        end
    end

    assign maxp = fcpm_pkg::eff_max(i_cfg.full_pwm);

    // Point count saturated to the slot count, and the last valid point.
    assign t_in  = 10'(i_temperature);
    assign n_sat = (i_cfg.point_count > 4'(POINT_SLOTS)) ? 4'(POINT_SLOTS)
                                                         : i_cfg.point_count;
    assign last  = IDX_W'(n_sat - 4'd1);

    // Compare the temperature with every point at once.
    always_comb begin
        for (int k = 0; k < POINT_SLOTS; k++) begin
            le[k] = (t_in <= $signed({2'b00, pt_temp[k]}));
        end
    end

    // The segment is the first one whose upper point is not below the temperature.
    always_comb begin
        seg_found = 1'b0;
        seg_idx   = '0;
        for (int i = 0; i < POINT_SLOTS - 1; i++) begin
            if (!seg_found && ((4'(i) + 4'd1) < n_sat) && le[i+1]) begin
                seg_found = 1'b1;
                seg_idx   = IDX_W'(i);
            end
        end
    end

    // Classify the item.
    always_comb begin
        n_idx = '0;
        if (n_sat >= 4'd2) begin
            priority if (le[0]) begin
                n_kind = K_PCT_CONST;
            end else if (t_in >= $signed({2'b00, pt_temp[last]})) begin
                n_kind = K_PCT_CONST;
                n_idx  = last;
            end else begin
                n_kind = K_PCT_SEG;
                n_idx  = seg_idx;
            end
        end else begin
            priority if (t_in < $signed({2'b00, i_cfg.fb_start_temp})) begin
                n_kind = K_FB_ZERO;
            end else if (t_in >= $signed(10'(fcpm_pkg::TOP_TEMP))) begin
                n_kind = K_FB_FULL;
            end else begin
                n_kind = K_FB_LINE;
            end
        end
    end

    // Classification register: valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    // Classification register: payload.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind <= n_kind;
            r_idx  <= n_idx;
            r_t    <= t_in;
        end
    end

    // Operands of the segment around the classified index.
    assign idx_hi = r_idx + IDX_W'(1);
    assign t0     = pt_temp[r_idx];
    assign t1     = pt_temp[idx_hi];
    assign p0     = pt_pct[r_idx];
    assign p1     = pt_pct[idx_hi];
    assign dt     = $signed({2'b00, t1}) - $signed({2'b00, t0});

    // Shared multiplier for the curve slope and the fallback slope.
    always_comb begin
        unique case (r_kind)
            K_PCT_SEG: begin
                mul_a = r_t - $signed({2'b00, t0});
                mul_b = $signed({2'b00, p1}) - $signed({2'b00, p0});
            end
            K_FB_LINE: begin
                mul_a = r_t - $signed({2'b00, i_cfg.fb_start_temp});
                mul_b = $signed({1'b0, maxp}) - $signed({1'b0, i_cfg.fb_start_pwm});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Build the queued item.
    always_comb begin
        o_item.side.is_curve = 1'b0;
        o_item.side.t_pos    = (r_t > 10'sd0);
        o_item.side.addend   = 8'd0;
        o_item.num           = '0;
        o_item.den           = 8'd1;
        unique case (r_kind)
            K_PCT_CONST: begin
                o_item.side.is_curve = 1'b1;
                o_item.side.addend   = {1'b0, p0};
            end
            K_PCT_SEG: begin
                o_item.side.is_curve = 1'b1;
                o_item.side.addend   = {1'b0, p0};
                // A segment of zero or negative width gives its lower percent.
                if (dt > 10'sd0) begin
                    o_item.num = prod[fcpm_pkg::NUM_W-1:0];
                    o_item.den = dt[7:0];
                end
            end
            K_FB_ZERO: begin
                o_item.side.addend = 8'd0;
            end
            K_FB_FULL: begin
                o_item.side.addend = maxp;
            end
            K_FB_LINE: begin
                o_item.side.addend = i_cfg.fb_start_pwm;
                o_item.num         = prod[fcpm_pkg::NUM_W-1:0];
                o_item.den         = 8'(fcpm_pkg::TOP_TEMP) - i_cfg.fb_start_temp;
            end
            default: begin
                o_item.side.addend = 8'd0;
            end
        endcase
    end

    assign o_push = r_vld;

endmodule

// File: design/fcpm_queue.sv
// ============================================================================
// Fan curve item queue
// Short first-in first-out queue between the front end and the back end.
// ============================================================================
module fcpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fcpm_pkg::t_item  i_item,
    input  logic             i_pop,
    output fcpm_pkg::t_item  o_item,
    output logic             o_empty,
    output logic             o_full
);

    localparam int DEPTH = fcpm_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    fcpm_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_pop  = i_pop && !o_empty;
    assign do_push = i_push && (!o_full || do_pop);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/fcpm_div.sv
// ============================================================================
// Fan curve divider
// Pipelined truncating signed divide of a small numerator by an 8-bit
// denominator, two quotient bits per stage.
// ============================================================================
module fcpm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic signed [fcpm_pkg::NUM_W-1:0]  i_num,
    input  logic [7:0]                         i_den,
    input  fcpm_pkg::t_side                    i_side,
    output logic                               o_vld,
    output logic [fcpm_pkg::QUO_W-1:0]         o_quo,
    output logic                               o_neg,
    output fcpm_pkg::t_side                    o_side
);

    localparam int NW  = fcpm_pkg::MAG_W;
    localparam int QW  = fcpm_pkg::QUO_W;
    localparam int BPS = fcpm_pkg::DIV_BPS;
    localparam int STG = QW / BPS;

    logic [STG:0]      r_vld;
    logic [NW-1:0]     r_rem  [STG+1];
    logic [QW-1:0]     r_quo  [STG+1];
    logic [7:0]        r_den  [STG+1];
    logic              r_neg  [STG+1];
    fcpm_pkg::t_side   r_side [STG+1];
    logic [NW-1:0]     n_rem  [STG];
    logic [QW-1:0]     n_quo  [STG];
    logic signed [fcpm_pkg::NUM_W-1:0] num_abs;

    // Input stage: split the numerator into sign and magnitude.
    assign num_abs = i_num[fcpm_pkg::NUM_W-1] ? -i_num : i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= num_abs[NW-1:0];
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_neg[0]  <= i_num[fcpm_pkg::NUM_W-1];
        r_side[0] <= i_side;
    end

    // Restoring division, most significant quotient bit first.
    for (genvar g = 0; g < STG; g++) begin : g_stage
        always_comb begin : step
            logic [NW-1:0] rem;
            logic [QW-1:0] quo;
            logic [NW:0]   trial;
            rem = r_rem[g];
            quo = r_quo[g];
            for (int b = 0; b < BPS; b++) begin
                trial = {1'b0, rem} - ((NW+1)'(r_den[g]) << (QW - 1 - g*BPS - b));
                if (!trial[NW]) begin
                    rem = trial[NW-1:0];
                    quo[QW - 1 - g*BPS - b] = 1'b1;
                end
            end
            n_rem[g] = rem;
            n_quo[g] = quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem[g];
            r_quo[g+1]  <= n_quo[g];
            r_den[g+1]  <= r_den[g];
            r_neg[g+1]  <= r_neg[g];
            r_side[g+1] <= r_side[g];
        end
    end

    assign o_vld  = r_vld[STG];
    assign o_quo  = r_quo[STG];
    assign o_neg  = r_neg[STG];
    assign o_side = r_side[STG];

endmodule

// File: design/fcpm_back.sv
// ============================================================================
// Fan curve back end
// Divides, adds the base, scales a curve percent to PWM and clamps the drive
// value into the output register.
// ============================================================================
module fcpm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_full_pwm,
    input  logic                    i_vld,
    input  fcpm_pkg::t_item         i_item,
    output logic                    o_valid,
    output logic                    o_update,
    output logic [7:0]              o_fan_pwm,
    output logic signed [7:0]       o_curve_percent
);

    logic [7:0]                     maxp;
    logic                           div_vld;
    logic [fcpm_pkg::QUO_W-1:0]     div_quo;
    logic                           div_neg;
    fcpm_pkg::t_side                div_side;

    logic signed [9:0]              quo_s;
    logic                           r1_vld;
    logic signed [9:0]              r1_val;
    fcpm_pkg::t_side                r1_side;

    logic                           r2_vld;
    logic signed [9:0]              r2_val;
    logic [14:0]                    r2_x;
    logic                           r2_zero;
    logic                           r2_full;
    fcpm_pkg::t_side                r2_side;

    logic [27:0]                    scaled;
    logic [7:0]                     n_pwm;
    logic                           r_valid;
    logic                           r_update;
    logic [7:0]                     r_pwm;
    logic signed [7:0]              r_pct;

    assign maxp = fcpm_pkg::eff_max(i_full_pwm);

    fcpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_num   (i_item.num),
        .i_den   (i_item.den),
        .i_side  (i_item.side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_side  (div_side)
    );

    // Base plus signed quotient.
    assign quo_s = div_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r1_vld  <= div_vld;
            r2_vld  <= r1_vld;
            r_valid <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_val  <= $signed({2'b00, div_side.addend}) + quo_s;
        r1_side <= div_side;
    end

    // Percent times full scale, and the percent range checks.
    always_ff @(posedge i_clk) begin
        r2_val  <= r1_val;
        r2_x    <= 15'(r1_val[6:0]) * 15'(maxp);
        r2_zero <= (r1_val == 10'sd0);
        r2_full <= (r1_val >= $signed(10'(fcpm_pkg::FULL_PERCENT)));
        r2_side <= r1_side;
    end

    // Divide by one hundred through the reciprocal, then select and clamp.
    assign scaled = 28'(r2_x) * 28'(fcpm_pkg::PCT_RECIP);

    always_comb begin
        if (r2_side.is_curve) begin
            priority if (r2_zero) begin
                n_pwm = 8'd0;
            end else if (r2_full) begin
                n_pwm = maxp;
            end else begin
                n_pwm = scaled[fcpm_pkg::PCT_SHIFT +: 8];
            end
        end else begin
            priority if (r2_val < 10'sd0) begin
                n_pwm = 8'd0;
            end else if (r2_val > $signed({2'b00, maxp})) begin
                n_pwm = maxp;
            end else begin
                n_pwm = r2_val[7:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_update <= r2_side.t_pos;
        r_pwm    <= r2_side.t_pos ? n_pwm : 8'd0;
        r_pct    <= r2_side.is_curve ? r2_val[7:0] : fcpm_pkg::PCT_NONE;
    end

    assign o_valid         = r_valid;
    assign o_update        = r_update;
    assign o_fan_pwm       = r_pwm;
    assign o_curve_percent = r_pct;

endmodule

// File: design/fan_curve_pwm_map.sv
// ============================================================================
// Fan curve PWM map
// The strobe o_valid follows an accepted item through the front register, the
// queue, divider and back-end registers; one item can be accepted every cycle.
// The divider pipeline and the output stage never stall, so busy is low
// outside reset; it is held high while reset is asserted.
// Reset clears the pipeline and loads the register defaults; no clearing pass.
// ============================================================================
module fan_curve_pwm_map #(
    parameter int POINT_SLOTS = fcpm_pkg::POINT_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [8:0]                   i_temperature,
    output logic                                o_valid,
    output logic                                o_update,
    output logic [7:0]                          o_fan_pwm,
    output logic signed [7:0]                   o_curve_percent,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fcpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fcpm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    fcpm_pkg::t_cfg     r_cfg;
    logic               accept;
    logic               push;
    fcpm_pkg::t_item    front_item;
    fcpm_pkg::t_item    head_item;
    logic               q_empty;
    logic               q_full;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign busy        = q_full || !i_rst_n;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pts_lo        <= '0;
            r_cfg.pts_hi        <= '0;
            r_cfg.point_count   <= '0;
            r_cfg.full_pwm      <= fcpm_pkg::FULL_PWM_RST;
            r_cfg.fb_start_pwm  <= fcpm_pkg::FB_PWM_RST;
            r_cfg.fb_start_temp <= fcpm_pkg::FB_TEMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fcpm_pkg::REG_PTS_LO:   r_cfg.pts_lo        <= i_cfg_data;
                fcpm_pkg::REG_PTS_HI:   r_cfg.pts_hi        <= i_cfg_data;
                fcpm_pkg::REG_COUNT:    r_cfg.point_count   <= i_cfg_data[3:0];
                fcpm_pkg::REG_FULL_PWM: r_cfg.full_pwm      <= i_cfg_data[7:0];
                fcpm_pkg::REG_FB_PWM:   r_cfg.fb_start_pwm  <= i_cfg_data[7:0];
                fcpm_pkg::REG_FB_TEMP:  r_cfg.fb_start_temp <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fcpm_front #(
        .POINT_SLOTS (POINT_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_temperature (i_temperature),
        .o_push        (push),
        .o_item        (front_item)
    );

    // The back end takes the head item whenever the queue holds one.
    fcpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (!q_empty),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fcpm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_pwm      (r_cfg.full_pwm),
        .i_vld           (!q_empty),
        .i_item          (head_item),
        .o_valid         (o_valid),
        .o_update        (o_update),
        .o_fan_pwm       (o_fan_pwm),
        .o_curve_percent (o_curve_percent)
    );

endmodule

// File: sim/tb_fan_curve_pwm_map.sv
`timescale 1ns / 1ps
// ============================================================================
// Fan curve PWM map testbench
// Sends temperatures through the fan curve block under several curve and
// fallback settings. Each result is checked in order against a table value
// or a local prediction built from a copy of the written registers.
// ============================================================================
module tb_fan_curve_pwm_map;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 127;
    localparam int CFG_W        = fcpm_pkg::CFG_DATA_W;

    // One result of the block
    typedef struct packed {
        logic              upd;
        logic [7:0]        pwm;
        logic signed [7:0] pct;
    } t_fan_res;

    // One row of the directed table: a register write or an item
    typedef struct packed {
        logic                 is_cfg;
        fcpm_pkg::t_reg_idx   reg_sel;
        logic [CFG_W-1:0]     wdata;
        logic signed [8:0]    temp;
        logic                 typed;
        t_fan_res             res;
    } t_stim_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic signed [8:0]                  i_temperature;
    logic                               o_valid;
    logic                               o_update;
    logic [7:0]                         o_fan_pwm;
    logic signed [7:0]                  o_curve_percent;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [fcpm_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]                   i_cfg_data;

    // Local copy of the curve registers, at their reset values
    logic [CFG_W-1:0]             cur_pts_lo  = '0;
    logic [CFG_W-1:0]             cur_pts_hi  = '0;
    logic [fcpm_pkg::COUNT_W-1:0] cur_count   = '0;
    logic [7:0]                   cur_full    = fcpm_pkg::FULL_PWM_RST;
    logic [7:0]                   cur_fb_pwm  = fcpm_pkg::FB_PWM_RST;
    logic [7:0]                   cur_fb_temp = fcpm_pkg::FB_TEMP_RST;

    t_fan_res pending_pwm[$];
    t_fan_res want;
    int       fail_count  = 0;
    int       idle_cycles = 0;
    int       gap_pct     = 0;

    fan_curve_pwm_map dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_temperature   (i_temperature),
        .o_valid         (o_valid),
        .o_update        (o_update),
        .o_fan_pwm       (o_fan_pwm),
        .o_curve_percent (o_curve_percent),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Temperature of curve point k.
    function automatic int knot_temp(int k);
        logic [CFG_W-1:0] word;
        word = (k < fcpm_pkg::SLOTS_PER_WORD) ? cur_pts_lo : cur_pts_hi;
        return int'(word[fcpm_pkg::SLOT_W*(k % fcpm_pkg::SLOTS_PER_WORD) +: 8]);
    endfunction

    // Percent of curve point k.
    function automatic int knot_pct(int k);
        logic [CFG_W-1:0] word;
        word = (k < fcpm_pkg::SLOTS_PER_WORD) ? cur_pts_lo : cur_pts_hi;
        return int'(word[fcpm_pkg::SLOT_W*(k % fcpm_pkg::SLOTS_PER_WORD) + 8 +: 7]);
    endfunction

    // Fan drive that the current registers give for one temperature.
    function automatic t_fan_res fan_drive_for(logic signed [8:0] temp);
        t_fan_res r;
        int       t, n, i, pct, pwm, maxp, t0, p0, dt, st, sp;
        logic     found;
        t    = temp;
        n    = (cur_count > fcpm_pkg::POINT_SLOTS_DEF) ? fcpm_pkg::POINT_SLOTS_DEF
                                                      : cur_count;
        maxp = (cur_full == 8'd0) ? 255 : cur_full;

        // Clamp at the end points, else interpolate inside the first segment
        // whose upper point is not below the temperature.
        if (n < 2) begin
            pct = -1;
        end else if (t <= knot_temp(0)) begin
            pct = knot_pct(0);
        end else if (t >= knot_temp(n - 1)) begin
            pct = knot_pct(n - 1);
        end else begin
            pct   = knot_pct(n - 1);
            found = 1'b0;
            for (i = 0; i + 1 < n && !found; i++) begin
                if (t <= knot_temp(i + 1)) begin
                    found = 1'b1;
                    t0    = knot_temp(i);
                    p0    = knot_pct(i);
                    dt    = knot_temp(i + 1) - t0;
                    pct   = (dt <= 0) ? p0 : p0 + (t - t0) * (knot_pct(i + 1) - p0) / dt;
                end
            end
        end

        // Scale the percent, or follow the fallback line without a curve.
        if (pct >= 0) begin
            if (pct == 0)
                pwm = 0;
            else if (pct >= fcpm_pkg::FULL_PERCENT)
                pwm = maxp;
            else
                pwm = pct * maxp / fcpm_pkg::FULL_PERCENT;
        end else begin
            st = cur_fb_temp;
            sp = cur_fb_pwm;
            if (t < st)
                pwm = 0;
            else if (t >= fcpm_pkg::TOP_TEMP)
                pwm = maxp;
            else
                pwm = (t - st) * (maxp - sp) / (fcpm_pkg::TOP_TEMP - st) + sp;
        end
        if (pwm < 0)
            pwm = 0;
        if (pwm > maxp)
            pwm = maxp;

        r.upd = (t > 0);
        r.pwm = (t > 0) ? pwm[7:0] : 8'd0;
        r.pct = pct[7:0];
        return r;
    endfunction

    // Table row builders.
    function automatic t_stim_row cfg_row(fcpm_pkg::t_reg_idx idx,
                                         logic [CFG_W-1:0] data);
        t_stim_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.wdata   = data;
        return r;
    endfunction

    function automatic t_stim_row item_row(logic signed [8:0] temp);
        t_stim_row r;
        r      = '0;
        r.temp = temp;
        return r;
    endfunction

    function automatic t_stim_row known_row(logic signed [8:0] temp, logic upd,
                                            logic [7:0] pwm, logic signed [7:0] pct);
        t_stim_row r;
        r         = '0;
        r.temp    = temp;
        r.typed   = 1'b1;
        r.res.upd = upd;
        r.res.pwm = pwm;
        r.res.pct = pct;
        return r;
    endfunction

    // Offer one temperature after random gaps and queue its expected result
    // once the item is taken.
    task automatic send_temp(logic signed [8:0] temp, logic typed, t_fan_res typed_res);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < gap_pct) begin
            start         <= 1'b0;
            i_temperature <= 9'($urandom);
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_temperature <= temp;
        do @(posedge i_clk); while (busy);
        pending_pwm.push_back(typed ? typed_res : fan_drive_for(temp));
    endtask

    // Write one register once every pending result is out.
    task automatic write_reg(fcpm_pkg::t_reg_idx idx, logic [CFG_W-1:0] data);
        start <= 1'b0;
        while (pending_pwm.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fcpm_pkg::REG_PTS_LO:   cur_pts_lo  = data;
            fcpm_pkg::REG_PTS_HI:   cur_pts_hi  = data;
            fcpm_pkg::REG_COUNT:    cur_count   = data[fcpm_pkg::COUNT_W-1:0];
            fcpm_pkg::REG_FULL_PWM: cur_full    = data[7:0];
            fcpm_pkg::REG_FB_PWM:   cur_fb_pwm  = data[7:0];
            fcpm_pkg::REG_FB_TEMP:  cur_fb_temp = data[7:0];
            default: ;
        endcase
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_pwm.size() == 0) begin
                $error("result with no item pending: update %0b, fan_pwm %0d, curve_percent %0d",
                       o_update, o_fan_pwm, o_curve_percent);
                fail_count++;
            end else begin
                want = pending_pwm.pop_front();
                if (o_update !== want.upd) begin
                    $error("update: expected %0b, got %0b", want.upd, o_update);
                    fail_count++;
                end
                if (o_fan_pwm !== want.pwm) begin
                    $error("fan_pwm: expected %0d, got %0d", want.pwm, o_fan_pwm);
                    fail_count++;
                end
                if (o_curve_percent !== want.pct) begin
                    $error("curve_percent: expected %0d, got %0d", want.pct, o_curve_percent);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fan_curve_pwm_map regression: fail");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases under three gap rates.
    initial begin
        t_stim_row                    dir_tab[$];
        t_stim_row                    row;
        int                           seg, ph, k, n, kt, tv, pick;
        logic [CFG_W-1:0]             lo, hi;
        logic [7:0]                   full_v, fbp_v, fbt_v;
        logic [fcpm_pkg::COUNT_W-1:0] count_v;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_temperature <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        gap_pct        = 21;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no curve, fallback from 45 degrees at 35 up to 255.
        dir_tab.push_back(known_row(-9'sd128, 1'b0, 8'd0, -8'sd1));
        dir_tab.push_back(known_row(9'sd0, 1'b0, 8'd0, -8'sd1));
        dir_tab.push_back(known_row(9'sd1, 1'b1, 8'd0, -8'sd1));
        dir_tab.push_back(known_row(9'sd44, 1'b1, 8'd0, -8'sd1));
        dir_tab.push_back(known_row(9'sd45, 1'b1, 8'd35, -8'sd1));
        dir_tab.push_back(item_row(9'sd119));
        dir_tab.push_back(item_row(9'sd82));
        dir_tab.push_back(known_row(9'sd120, 1'b1, 8'd255, -8'sd1));
        dir_tab.push_back(known_row(9'sd255, 1'b1, 8'd255, -8'sd1));
        // Two points: 20 degrees at 0 percent, 100 degrees at 100 percent.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_PTS_LO, 63'h0000_0000_6464_0014));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_COUNT, 63'd2));
        dir_tab.push_back(known_row(9'sd10, 1'b1, 8'd0, 8'sd0));
        dir_tab.push_back(known_row(9'sd100, 1'b1, 8'd255, 8'sd100));
        dir_tab.push_back(known_row(9'sd200, 1'b1, 8'd255, 8'sd100));
        dir_tab.push_back(item_row(9'sd60));
        dir_tab.push_back(known_row(-9'sd5, 1'b0, 8'd0, 8'sd0));
        // A full scale of zero counts as 255; then the smallest full scale.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FULL_PWM, 63'd0));
        dir_tab.push_back(known_row(9'sd150, 1'b1, 8'd255, 8'sd100));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FULL_PWM, 63'd1));
        dir_tab.push_back(item_row(9'sd60));
        // A point above one hundred percent saturates the drive.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FULL_PWM, 63'd200));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_PTS_LO, 63'h0000_0000_7F64_0014));
        dir_tab.push_back(known_row(9'sd100, 1'b1, 8'd200, 8'sd127));
        dir_tab.push_back(item_row(9'sd70));
        // A count above the slot number is cut to eight; the empty slots read 0.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_PTS_HI, 63'd0));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_COUNT, 63'd15));
        dir_tab.push_back(known_row(9'sd50, 1'b1, 8'd0, 8'sd0));
        // Repeated point temperatures.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_PTS_LO, 63'h0000_3C5A_5028_1428));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_COUNT, 63'd3));
        dir_tab.push_back(item_row(9'sd40));
        dir_tab.push_back(item_row(9'sd60));
        // Fallback start above 120 degrees.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_COUNT, 63'd0));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FULL_PWM, 63'd255));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FB_TEMP, 63'd130));
        dir_tab.push_back(known_row(9'sd125, 1'b1, 8'd0, -8'sd1));
        dir_tab.push_back(known_row(9'sd130, 1'b1, 8'd255, -8'sd1));
        // Fallback start drive above the full scale is clamped.
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FULL_PWM, 63'd100));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FB_PWM, 63'd200));
        dir_tab.push_back(cfg_row(fcpm_pkg::REG_FB_TEMP, 63'd45));
        dir_tab.push_back(known_row(9'sd45, 1'b1, 8'd100, -8'sd1));
        dir_tab.push_back(item_row(9'sd80));

        for (k = 0; k < dir_tab.size(); k++) begin
            row = dir_tab[k];
            if (row.is_cfg)
                write_reg(row.reg_sel, row.wdata);
            else
                send_temp(row.temp, row.typed, row.res);
        end

        // Random phases, each with its own settings.
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0:       gap_pct = 21;
                1:       gap_pct = 47;
                default: gap_pct = 0;
            endcase
            for (ph = 0; ph < 5; ph++) begin
                lo      = CFG_W'({$urandom, $urandom});
                hi      = CFG_W'({$urandom, $urandom});
                count_v = 4'($urandom_range(0, 15));
                full_v  = 8'($urandom_range(1, 255));
                fbp_v   = 8'($urandom);
                fbt_v   = 8'($urandom_range(0, 150));
                pick    = $urandom_range(0, 9);
                if (pick < 6) begin
                    // Well-formed curve: strictly rising temperatures up to 150.
                    n  = $urandom_range(2, fcpm_pkg::POINT_SLOTS_DEF);
                    kt = $urandom_range(0, 40);
                    for (k = 0; k < n; k++) begin
                        if (kt > 150) begin
                            n = k;
                        end else begin
                            if (k < fcpm_pkg::SLOTS_PER_WORD)
                                lo[fcpm_pkg::SLOT_W*k +: 15] =
                                    {7'($urandom_range(0, 100)), 8'(kt)};
                            else
                                hi[fcpm_pkg::SLOT_W*(k-fcpm_pkg::SLOTS_PER_WORD) +: 15] =
                                    {7'($urandom_range(0, 100)), 8'(kt)};
                            kt += $urandom_range(1, 30);
                        end
                    end
                    count_v = 4'(n);
                end else if (pick == 6) begin
                    // Fallback line only.
                    count_v = 4'($urandom_range(0, 1));
                end else if (pick == 7) begin
                    // Register extremes.
                    case ($urandom_range(0, 2))
                        0:       full_v = 8'd0;
                        1:       full_v = 8'd1;
                        default: full_v = 8'd255;
                    endcase
                    fbp_v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    case ($urandom_range(0, 4))
                        0:       fbt_v = 8'd0;
                        1:       fbt_v = 8'd119;
                        2:       fbt_v = 8'd120;
                        3:       fbt_v = 8'd150;
                        default: fbt_v = 8'd255;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       count_v = 4'd0;
                        1:       count_v = 4'd1;
                        2:       count_v = 4'd8;
                        default: count_v = 4'd15;
                    endcase
                    lo = $urandom_range(0, 1) ? '1 : '0;
                    hi = $urandom_range(0, 1) ? '1 : '0;
                end else if ($urandom_range(0, 1)) begin
                    // Noise: random words and count, start temperature anywhere in 0 to 255.
                    fbt_v = 8'($urandom);
                end

                write_reg(fcpm_pkg::REG_PTS_LO, lo);
                write_reg(fcpm_pkg::REG_PTS_HI, hi);
                write_reg(fcpm_pkg::REG_COUNT, CFG_W'(count_v));
                write_reg(fcpm_pkg::REG_FULL_PWM, CFG_W'(full_v));
                write_reg(fcpm_pkg::REG_FB_PWM, CFG_W'(fbp_v));
                write_reg(fcpm_pkg::REG_FB_TEMP, CFG_W'(fbt_v));

                // Mostly the working range, some of the whole range, and some
                // right around the point temperatures.
                for (k = 0; k < PHASE_ITEMS; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        tv = $urandom_range(0, 160);
                    else if (pick < 9)
                        tv = $urandom_range(0, 383) - 128;
                    else
                        tv = knot_temp($urandom_range(0, fcpm_pkg::POINT_SLOTS_DEF - 1))
                             + $urandom_range(0, 4) - 2;
                    if (tv > 255)
                        tv = 255;
                    send_temp(9'(tv), 1'b0, '0);
                end
            end
        end

        // Let every result come out, then allow for stray strobes.
        start <= 1'b0;
        while (pending_pwm.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("fan_curve_pwm_map regression: pass");
        else
            $display("fan_curve_pwm_map regression: fail");
        $finish;
    end

endmodule
